>>> rtl/core/fifo_queue_with_search_defines.svh
// Assertion helpers used by the checker file fqws_checker.sv.
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Checked on every edge once reset is released.
`define FQWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define FQWS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fqws_pkg.sv
`timescale 1ns / 1ps

package fqws_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int MATCH_W  = 4;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REPORT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    key_t                key;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                popped_key;
    logic [MATCH_W-1:0]  match_position;
    logic [COUNT_W-1:0]  entry_count;
    key_t                head_key;
    key_t                tail_key;
    logic                is_empty;
  } res_t;

  localparam ptr_t LAST_IDX = PTR_W'(DEPTH - 1);
  localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

  function automatic ptr_t ring_next(input ptr_t i);
    ring_next = (i == LAST_IDX) ? '0 : i + ptr_t'(1);
  endfunction

endpackage

>>> rtl/core/fqws_if.sv
`timescale 1ns / 1ps

interface fqws_in_if import fqws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  key_t                key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface fqws_out_if import fqws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  key_t                popped_key;
  logic [MATCH_W-1:0]  match_position;
  logic [COUNT_W-1:0]  entry_count;
  key_t                head_key;
  key_t                tail_key;
  logic                is_empty;

  modport source (output valid, output status, output popped_key, output match_position,
                  output entry_count, output head_key, output tail_key, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input popped_key, input match_position,
                  input entry_count, input head_key, input tail_key, input is_empty,
                  output ready);
endinterface

>>> rtl/core/fqws_front.sv
`timescale 1ns / 1ps

module fqws_front import fqws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fqws_in_if.sink     in_if,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  localparam int QD     = 2;
  localparam int QPTR_W = $clog2(QD);
  localparam int QCNT_W = $clog2(QD + 1);

  cmd_t               q_r [QD];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;
  cmd_t               cls;

  // Unused codes fold into report.
  always_comb begin
    cls.key = in_if.key;
    unique case (in_if.action) inside
      ACT_PUSH, ACT_POP, ACT_SEARCH, ACT_CLEAR: cls.action = in_if.action;
      default:                                  cls.action = ACT_REPORT;
    endcase
  end

  assign in_if.ready = (cnt_r != QCNT_W'(QD));
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_valid && cmd_take;
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == QPTR_W'(QD - 1)) ? '0 : wr_ptr_r + QPTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ((rd_ptr_r == QPTR_W'(QD - 1)) ? '0 : rd_ptr_r + QPTR_W'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> rtl/core/fqws_back.sv
`timescale 1ns / 1ps

module fqws_back import fqws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  fqws_out_if.source  out_if
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  ptr_t                head_r, head_nxt;
  ptr_t                tail_r, tail_nxt;
  cnt_t                occ_r, occ_nxt;
  key_t                head_key_r, head_key_nxt;
  key_t                tail_key_r, tail_key_nxt;
  key_t                key_r, key_nxt;
  ptr_t                pos_r, pos_nxt;
  ptr_t                idx_r, idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  key_t                popped_r, popped_nxt;
  ptr_t                match_r, match_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_r, out_nxt;

  key_t                mem [DEPTH];
  key_t                rd_data_r;
  ptr_t                rd_addr;
  logic                wr_en;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    head_key_nxt  = head_key_r;
    tail_key_nxt  = tail_key_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    match_nxt     = match_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    wr_en         = 1'b0;
    rd_addr       = head_r;
    cmd_take      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          status_nxt = ST_OK;
          popped_nxt = '0;
          match_nxt  = '0;
          state_nxt  = S_DONE;
          unique case (cmd.action)
            ACT_PUSH: begin
              if (occ_r == CNT_FULL) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                tail_nxt     = ring_next(tail_r);
                occ_nxt      = occ_r + cnt_t'(1);
                tail_key_nxt = cmd.key;
                if (occ_r == '0) begin
                  head_key_nxt = cmd.key;
                end
              end
            end
            ACT_POP: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt = head_key_r;
                head_nxt   = ring_next(head_r);
                occ_nxt    = occ_r - cnt_t'(1);
                // fetch the new head word unless the queue drains
                rd_addr    = ring_next(head_r);
                if (occ_r != cnt_t'(1)) begin
                  state_nxt = S_LOAD;
                end
              end
            end
            ACT_SEARCH: begin
              if (occ_r == '0) begin
                status_nxt = ST_MISS;
              end else begin
                key_nxt   = cmd.key;
                pos_nxt   = '0;
                idx_nxt   = ring_next(head_r);
                rd_addr   = head_r;
                state_nxt = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              occ_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        head_key_nxt = rd_data_r;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        // rd_data_r holds the word at pos_r; prefetch the next one
        rd_addr = idx_r;
        if (rd_data_r == key_r) begin
          match_nxt = pos_r;
          state_nxt = S_DONE;
        end else if (cnt_t'(pos_r) + cnt_t'(1) == occ_r) begin
          status_nxt = ST_MISS;
          state_nxt  = S_DONE;
        end else begin
          pos_nxt = pos_r + ptr_t'(1);
          idx_nxt = ring_next(idx_r);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_nxt.status         = status_r;
          out_nxt.popped_key     = popped_r;
          out_nxt.match_position = MATCH_W'(match_r);
          out_nxt.entry_count    = COUNT_W'(occ_r);
          out_nxt.head_key       = (occ_r != '0) ? head_key_r : '0;
          out_nxt.tail_key       = (occ_r != '0) ? tail_key_r : '0;
          out_nxt.is_empty       = (occ_r == '0);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_key_r <= head_key_nxt;
    tail_key_r <= tail_key_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    popped_r   <= popped_nxt;
    match_r    <= match_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= cmd.key;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_r.status;
  assign out_if.popped_key     = out_r.popped_key;
  assign out_if.match_position = out_r.match_position;
  assign out_if.entry_count    = out_r.entry_count;
  assign out_if.head_key       = out_r.head_key;
  assign out_if.tail_key       = out_r.tail_key;
  assign out_if.is_empty       = out_r.is_empty;

endmodule

>>> rtl/core/fifo_queue_with_search.sv
`timescale 1ns / 1ps

// Queue of signed 32-bit keys in a 16-entry ring, one result word per command word.
// A two-word command queue takes input words independently of the execute side, and
// a result register lets the next command start while a result waits. Push, clear and
// report pass through the execute states IDLE and DONE, a pop that leaves entries
// behind also passes through LOAD (the new head key is read from the key memory), and
// a search stays in SCAN until a match or until every entry has been compared: the
// single read port of the key memory delivers one stored key per cycle.

module fifo_queue_with_search import fqws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fqws_in_if.sink    in_if,
  fqws_out_if.source out_if
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  fqws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  fqws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_if    (out_if)
  );

endmodule

>>> rtl/core/fqws_checker.sv
`timescale 1ns / 1ps
`include "fifo_queue_with_search_defines.svh"

module fqws_checker import fqws_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input key_t                out_popped_key,
  input logic [COUNT_W-1:0]  out_entry_count,
  input key_t                out_head_key,
  input key_t                out_tail_key,
  input logic                out_is_empty
);

  `FQWS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
  `FQWS_ASSERT(a_empty_keys, out_valid && out_is_empty |-> out_head_key == 0 && out_tail_key == 0 && out_entry_count == 0, "empty queue reports keys or count")
  `FQWS_ASSERT(a_count_max, out_valid |-> out_entry_count <= COUNT_W'(DEPTH), "entry count above depth")
  `FQWS_ASSERT(a_pop_empty, out_valid && out_status == ST_EMPTY |-> out_is_empty && out_popped_key == 0, "failed pop with data or entries")

endmodule

bind fifo_queue_with_search fqws_checker u_fqws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_popped_key  (out_if.popped_key),
  .out_entry_count (out_if.entry_count),
  .out_head_key    (out_if.head_key),
  .out_tail_key    (out_if.tail_key),
  .out_is_empty    (out_if.is_empty)
);

>>> bench/fqws_queue_checker.sv
`timescale 1ns / 1ps

module fqws_queue_checker import fqws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fqws_in_if          cmd,
  fqws_out_if         rsp,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  // shadow copy of the ring
  key_t        slots [DEPTH];
  ptr_t        rd_ptr;
  ptr_t        wr_ptr;
  int unsigned fill;

  res_t        expected_words [$];
  res_t        want;
  int unsigned errs = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what);
    errs++;
    $display("[%0t] fqws_check: %s", $time, what);
  endtask

  function automatic ptr_t step_ptr(input ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic res_t apply_action(input logic [ACTION_W-1:0] act, input key_t k);
    res_t        r;
    ptr_t        idx;
    int unsigned n;
    bit          hit;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[wr_ptr] = k;
          wr_ptr = step_ptr(wr_ptr);
          fill++;
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_key = slots[rd_ptr];
          rd_ptr = step_ptr(rd_ptr);
          fill--;
        end
      end
      ACT_SEARCH: begin
        // walk from the head; the oldest duplicate wins
        idx = rd_ptr;
        hit = 1'b0;
        n   = 0;
        while (!hit && n < fill) begin
          if (slots[idx] == k) begin
            hit = 1'b1;
            r.match_position = MATCH_W'(n);
          end else begin
            idx = step_ptr(idx);
            n++;
          end
        end
        if (!hit) begin
          r.status = ST_MISS;
        end
      end
      ACT_CLEAR: begin
        rd_ptr = '0;
        wr_ptr = '0;
        fill   = 0;
      end
      default: ;  // report, and the unused codes behave the same
    endcase
    r.entry_count = COUNT_W'(fill);
    r.is_empty    = (fill == 0);
    if (fill != 0) begin
      r.head_key = slots[rd_ptr];
      r.tail_key = slots[(wr_ptr == '0) ? ptr_t'(DEPTH - 1) : wr_ptr - ptr_t'(1)];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr = '0;
      wr_ptr = '0;
      fill   = 0;
      expected_words.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.popped_key !== want.popped_key)
            report_mismatch($sformatf("popped_key got %h want %h",
                                      rsp.popped_key, want.popped_key));
          if (rsp.match_position !== want.match_position)
            report_mismatch($sformatf("match_position got %0d want %0d",
                                      rsp.match_position, want.match_position));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      rsp.entry_count, want.entry_count));
          if (rsp.head_key !== want.head_key)
            report_mismatch($sformatf("head_key got %h want %h", rsp.head_key, want.head_key));
          if (rsp.tail_key !== want.tail_key)
            report_mismatch($sformatf("tail_key got %h want %h", rsp.tail_key, want.tail_key));
          if (rsp.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b want %b", rsp.is_empty, want.is_empty));
        end
      end
      if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
        expected_words.push_back(apply_action(cmd.action, cmd.key));
      end
    end
    fail_count    <= errs;
    pending_count <= expected_words.size();
  end

endmodule

>>> bench/fifo_queue_with_search_tb.sv
`timescale 1ns / 1ps

module fifo_queue_with_search_tb;
  import fqws_pkg::*;

  localparam int   RUN_WORDS    = 1350;
  localparam int   CYCLE_LIMIT  = 800000;
  localparam int   DRAIN_CYCLES = 40;
  localparam key_t KEY_MAX      = key_t'(32'h7FFF_FFFF);
  localparam key_t KEY_MIN      = key_t'(32'h8000_0000);

  logic        clk;
  logic        rst_n;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned pending;
  bit          burst_mode;

  fqws_in_if  in_ch ();
  fqws_out_if out_ch ();

  fifo_queue_with_search u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  fqws_queue_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (in_ch),
    .rsp           (out_ch),
    .fail_count    (mismatches),
    .pending_count (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Called at a rising edge; returns at the edge where the word was taken.
  // valid stays high across back-to-back words.
  task automatic send_word(input logic [ACTION_W-1:0] act, input key_t k);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= k;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int hi;
    int lo;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hi = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (hi) @(posedge clk);
      lo = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_ch.ready <= 1'b0;
      repeat (lo) @(posedge clk);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[fifo_queue_with_search] ERROR");
    $finish;
  end

  initial begin
    int                  push_w;
    int                  pop_w;
    int                  r;
    logic [ACTION_W-1:0] act;
    key_t                k;
    burst_mode   = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_REPORT;
    in_ch.key    <= '0;
    rst_n        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue corners
    send_word(ACT_REPORT, key_t'(32'h1234_5678));
    send_word(ACT_POP,    '0);
    send_word(ACT_SEARCH, '0);
    // fill to the brim with extremes and a duplicate near the head
    send_word(ACT_PUSH, KEY_MAX);
    send_word(ACT_PUSH, KEY_MIN);
    send_word(ACT_PUSH, KEY_MAX);
    send_word(ACT_PUSH, key_t'(-1));
    send_word(ACT_PUSH, '0);
    for (int i = 1; i <= 10; i++) send_word(ACT_PUSH, key_t'(i * 32'h0101_0101));
    send_word(ACT_PUSH, key_t'(32'h1357_9BDF));
    send_word(ACT_PUSH, key_t'(32'h5555_AAAA));      // full: rejected
    send_word(ACT_SEARCH, KEY_MAX);                   // first of two copies
    send_word(ACT_SEARCH, key_t'(32'h1357_9BDF));     // last slot
    send_word(ACT_SEARCH, key_t'(32'h5555_AAAA));     // miss
    send_word(ACT_POP, '0);
    send_word(ACT_REPORT | 3'd1, '0);
    send_word(ACT_REPORT | 3'd2, '0);
    send_word(ACT_REPORT | 3'd3, '0);
    send_word(ACT_CLEAR, '0);

    push_w = 35;
    pop_w  = 30;
    for (int i = 0; i < RUN_WORDS; i++) begin
      // phases that lean toward filling, draining or neither
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_w = 60; pop_w = 10; end
          1: begin push_w = 15; pop_w = 50; end
          default: begin push_w = 35; pop_w = 30; end
        endcase
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < push_w) act = ACT_PUSH;
      else if (r < push_w + pop_w) act = ACT_POP;
      else if (r < 95) act = ACT_SEARCH;
      else if (r < 99) act = ACT_REPORT | 3'($urandom_range(0, 3));
      else act = ACT_CLEAR;
      // narrow key pool so searches hit and duplicates appear
      case ($urandom_range(0, 3))
        0: k = key_t'($urandom);
        1: begin
          case ($urandom_range(0, 3))
            0: k = KEY_MAX;
            1: k = KEY_MIN;
            2: k = key_t'(-1);
            default: k = '0;
          endcase
        end
        default: k = key_t'($urandom_range(0, 24)) - key_t'(12);
      endcase
      send_word(act, k);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[fifo_queue_with_search] OK");
    end else begin
      $display("[fifo_queue_with_search] ERROR");
    end
    $finish;
  end

endmodule
